[rtl/oalc_pkg.sv]
// Shared constants, types and helpers of the open-addressing LRU cache.
package oalc_pkg;

  localparam int MAX_SLOTS   = 1024;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int CB_W        = $clog2(SLOT_W + 1);
  localparam int EVICT_SHIFT = 4;     // evict cap / 16 entries (one below 16 slots)

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_HASH_MULT   = 2'd1;

  localparam logic [9:0]  RESET_MAX_ENTRIES = 10'd682;
  localparam logic [63:0] RESET_HASH_MULT   = 64'd11400714819323198485;

  typedef struct packed {
    logic        used;
    logic [31:0] stamp;
    logic [31:0] value;
    logic [63:0] key;
  } entry_t;

  // log2 of the smallest power of two at least floor(1.5 * m), saturated
  function automatic logic [CB_W-1:0] cap_bits_of(input logic [9:0] m);
    logic [CNT_W-1:0] need;
    logic [CB_W-1:0]  cb;
    need = CNT_W'(({2'b00, m} * 12'd3) >> 1);
    cb   = CB_W'(SLOT_W);
    for (int b = SLOT_W; b >= 0; b--) begin
      if ((CNT_W'(1) << b) >= need) cb = CB_W'(b);
    end
    return cb;
  endfunction

endpackage

[rtl/oalc_hash.sv]
// Home-slot hash: 64-bit product built from 32x32 partial products on one multiplier.
module oalc_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [63:0]                   key,
  input  logic [63:0]                   mult,
  input  logic [oalc_pkg::CB_W-1:0]     cap_bits,
  output logic                          done,
  output logic [oalc_pkg::SLOT_W-1:0]   slot
);

  logic        busy;
  logic [2:0]  step;
  logic [63:0] k;
  logic [63:0] m;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_w;

  always_comb begin
    case (step)
      3'd1:    begin op_a = k[63:32]; op_b = m[31:0];  end
      3'd2:    begin op_a = k[31:0];  op_b = m[63:32]; end
      default: begin op_a = k[31:0];  op_b = m[31:0];  end
    endcase
  end

  assign prod_w = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 3'd0;
      k    <= key;
      m    <= mult;
    end else if (busy) begin
      prod <= prod_w;
      step <= step + 3'd1;
      case (step)
        3'd1:    acc <= prod;
        3'd2:    acc[63:32] <= acc[63:32] + prod[31:0];
        3'd3:    acc[63:32] <= acc[63:32] + prod[31:0];
        3'd4:    busy <= 1'b0;
        default: ;
      endcase
    end
  end

  assign done = busy && (step == 3'd4);
  // top cap_bits bits of the product; zero when the table has one slot
  assign slot = oalc_pkg::SLOT_W'(acc[63:64-oalc_pkg::SLOT_W]
                >> (oalc_pkg::CB_W'(oalc_pkg::SLOT_W) - cap_bits));

endmodule

[rtl/open_addressing_lru_cache_unit.sv]
// Top level of the open-addressing LRU cache: sequencer, slot memory and counters.
//
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | cmd, lookup_key, write_value
// out      | out_valid / out_stall| hit, read_value, occupancy, hit_total, miss_total
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. Lookup/insert: the key is hashed, then each probed slot is read
// and checked in turn (one read port), then the result is registered. An insert at
// capacity adds batch eviction: up to 33 counting sweeps, then one removal sweep or
// a clearing pass. Clear, reset and writes to max_entries or hash_multiplier run a
// clearing pass over all 1024 slots (in_stall high). Register writes are taken only
// when idle and hold off requests. A stalled result holds in the output register.
module open_addressing_lru_cache_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic signed [63:0] lookup_key,
  input  logic signed [31:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic signed [31:0] read_value,
  output logic [9:0]  occupancy,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int SW = oalc_pkg::SLOT_W;
  localparam int CW = oalc_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HASH = 4'd1;
  localparam logic [3:0] S_PRD  = 4'd2;
  localparam logic [3:0] S_PCHK = 4'd3;
  localparam logic [3:0] S_CNT  = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_SRCH = 4'd6;
  localparam logic [3:0] S_REM  = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic [1:0] RET_IDLE  = 2'd0;
  localparam logic [1:0] RET_FIN   = 2'd1;
  localparam logic [1:0] RET_EVICT = 2'd2;

  oalc_pkg::entry_t mem [oalc_pkg::MAX_SLOTS];
  oalc_pkg::entry_t rd_data;
  oalc_pkg::entry_t wd;
  logic             we;
  logic [SW-1:0]    wa;
  logic [SW-1:0]    ra;

  logic [3:0]    state;
  logic [1:0]    c_cmd;
  logic [63:0]   c_key;
  logic [31:0]   c_val;
  logic [SW-1:0] home;
  logic [SW-1:0] idx;
  logic [CW-1:0] pn;
  logic          free_mode;
  logic          r_hit;
  logic [31:0]   r_val;
  logic [31:0]   stamp_clock;
  logic [CW-1:0] used_count;
  logic [31:0]   hit_counter;
  logic [31:0]   miss_counter;
  logic [9:0]    max_entries;
  logic [63:0]   hash_multiplier;
  logic [31:0]   lo;
  logic [31:0]   hi;
  logic [31:0]   thresh;
  logic          first_pass;
  logic [CW-1:0] cnt;
  logic [CW-1:0] sweep_addr;
  logic          chk_vld;
  logic [SW-1:0] chk_addr;
  logic [SW-1:0] clr_addr;
  logic [1:0]    clr_ret;

  logic [oalc_pkg::CB_W-1:0] cap_bits;
  logic [CW-1:0] cap;
  logic [SW-1:0] mask;
  logic [CW-1:0] evict_k;
  logic          need_evict;
  logic          key_match;
  logic [SW-1:0] idx_inc;
  logic          in_acc;
  logic          hash_start;
  logic          hash_done;
  logic [SW-1:0] hash_slot;
  logic [32:0]   mid_sum;

  assign cap_bits   = oalc_pkg::cap_bits_of(max_entries);
  assign cap        = CW'(1) << cap_bits;
  assign mask       = SW'(cap - CW'(1));
  assign evict_k    = (cap_bits >= oalc_pkg::CB_W'(oalc_pkg::EVICT_SHIFT))
                      ? (cap >> oalc_pkg::EVICT_SHIFT) : CW'(1);
  assign need_evict = (used_count >= {1'b0, max_entries}) || (used_count >= cap);
  assign key_match  = rd_data.used && (rd_data.key == c_key);
  assign idx_inc    = (idx + SW'(1)) & mask;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};

  // a pending register write holds off requests
  assign in_stall   = (state != S_IDLE) || cfg_valid;
  assign in_acc     = in_valid && !in_stall;
  assign hash_start = in_acc && ((cmd == oalc_pkg::CMD_LOOKUP) || (cmd == oalc_pkg::CMD_INSERT));
  assign cfg_ready  = (state == S_IDLE);

  oalc_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .start    (hash_start),
    .key      (lookup_key),
    .mult     (hash_multiplier),
    .cap_bits (cap_bits),
    .done     (hash_done),
    .slot     (hash_slot)
  );

  assign ra = (state == S_PRD) ? idx : sweep_addr[SW-1:0];

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = rd_data;
    case (state)
      S_CLR: begin
        we = 1'b1;
        wa = clr_addr;
        wd = '0;
      end
      S_PCHK: begin
        if (!free_mode && key_match) begin
          we       = 1'b1;
          wd.stamp = stamp_clock + 32'd1;
          if (c_cmd == oalc_pkg::CMD_INSERT) wd.value = c_val;
        end else if (!rd_data.used && (free_mode ||
                     (c_cmd == oalc_pkg::CMD_INSERT && !need_evict))) begin
          we       = 1'b1;
          wd.used  = 1'b1;
          wd.stamp = stamp_clock + 32'd1;
          wd.value = c_val;
          wd.key   = c_key;
        end
      end
      S_REM: begin
        if (chk_vld && rd_data.used && (rd_data.stamp < thresh)) begin
          we      = 1'b1;
          wa      = chk_addr;
          wd.used = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      clr_addr        <= '0;
      clr_ret         <= RET_IDLE;
      out_valid       <= 1'b0;
      stamp_clock     <= '0;
      used_count      <= '0;
      hit_counter     <= '0;
      miss_counter    <= '0;
      max_entries     <= oalc_pkg::RESET_MAX_ENTRIES;
      hash_multiplier <= oalc_pkg::RESET_HASH_MULT;
      chk_vld         <= 1'b0;
      free_mode       <= 1'b0;
      first_pass      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            // register write empties the table
            if (cfg_index inside {oalc_pkg::REG_MAX_ENTRIES, oalc_pkg::REG_HASH_MULT}) begin
              if (cfg_index == oalc_pkg::REG_MAX_ENTRIES) max_entries <= cfg_data[9:0];
              else hash_multiplier <= cfg_data;
              used_count  <= '0;
              stamp_clock <= '0;
              clr_addr    <= '0;
              clr_ret     <= RET_IDLE;
              state       <= S_CLR;
            end
          end else if (in_acc) begin
            c_cmd <= cmd;
            c_key <= lookup_key;
            c_val <= write_value;
            r_hit <= 1'b0;
            r_val <= '0;
            if (hash_start) begin
              state <= S_HASH;
            end else if (cmd == oalc_pkg::CMD_CLEAR) begin
              hit_counter  <= '0;
              miss_counter <= '0;
              used_count   <= '0;
              stamp_clock  <= '0;
              clr_addr     <= '0;
              clr_ret      <= RET_FIN;
              state        <= S_CLR;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            home      <= hash_slot;
            idx       <= hash_slot;
            pn        <= '0;
            free_mode <= 1'b0;
            state     <= S_PRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (free_mode) begin
            if (!rd_data.used) begin
              used_count  <= used_count + CW'(1);
              stamp_clock <= stamp_clock + 32'd1;
              state       <= S_FIN;
            end else if (pn + CW'(1) == cap) begin
              state <= S_FIN;    // nothing free: insert dropped
            end else begin
              idx   <= idx_inc;
              pn    <= pn + CW'(1);
              state <= S_PRD;
            end
          end else if (key_match) begin
            stamp_clock <= stamp_clock + 32'd1;
            if (c_cmd == oalc_pkg::CMD_LOOKUP) begin
              hit_counter <= hit_counter + 32'd1;
              r_hit       <= 1'b1;
              r_val       <= rd_data.value;
            end
            state <= S_FIN;
          end else if (!rd_data.used || (pn + CW'(1) == cap)) begin
            if (c_cmd == oalc_pkg::CMD_LOOKUP) begin
              miss_counter <= miss_counter + 32'd1;
              state        <= S_FIN;
            end else if (need_evict) begin
              lo         <= '0;
              hi         <= '1;
              thresh     <= '1;
              first_pass <= 1'b1;
              sweep_addr <= '0;
              chk_vld    <= 1'b0;
              cnt        <= '0;
              state      <= S_CNT;
            end else begin
              if (!rd_data.used) begin
                used_count  <= used_count + CW'(1);
                stamp_clock <= stamp_clock + 32'd1;
              end
              state <= S_FIN;
            end
          end else begin
            idx   <= idx_inc;
            pn    <= pn + CW'(1);
            state <= S_PRD;
          end
        end
        S_CNT, S_REM: begin
          chk_vld  <= (sweep_addr < cap);
          chk_addr <= sweep_addr[SW-1:0];
          if (sweep_addr < cap) sweep_addr <= sweep_addr + CW'(1);
          if (state == S_CNT) begin
            if (chk_vld && rd_data.used && (rd_data.stamp <= thresh)) cnt <= cnt + CW'(1);
          end else if (chk_vld && rd_data.used && (rd_data.stamp < thresh)) begin
            used_count <= used_count - CW'(1);
          end
          if ((sweep_addr >= cap) && !chk_vld) begin
            if (state == S_CNT) begin
              state <= S_EVAL;
            end else begin
              idx       <= home;
              pn        <= '0;
              free_mode <= 1'b1;
              state     <= S_PRD;
            end
          end
        end
        S_EVAL: begin
          if (first_pass) begin
            first_pass <= 1'b0;
            if (cnt <= evict_k) begin
              // few enough occupied: drop them all
              used_count <= '0;
              clr_addr   <= '0;
              clr_ret    <= RET_EVICT;
              state      <= S_CLR;
            end else begin
              state <= S_SRCH;
            end
          end else begin
            if (cnt > evict_k) hi <= thresh;
            else lo <= thresh + 32'd1;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          sweep_addr <= '0;
          chk_vld    <= 1'b0;
          cnt        <= '0;
          if (lo < hi) begin
            thresh <= mid_sum[32:1];
            state  <= S_CNT;
          end else begin
            thresh <= lo;
            state  <= S_REM;
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + SW'(1);
          if (clr_addr == SW'(oalc_pkg::MAX_SLOTS - 1)) begin
            case (clr_ret)
              RET_FIN: state <= S_FIN;
              RET_EVICT: begin
                idx       <= home;
                pn        <= '0;
                free_mode <= 1'b1;
                state     <= S_PRD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            hit        <= r_hit;
            read_value <= r_val;
            occupancy  <= used_count[9:0];
            hit_total  <= hit_counter;
            miss_total <= miss_counter;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/oalc_checker.sv]
// Port-level checks of the cache unit, bound to the top level.
module oalc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [31:0] read_value,
  input logic [9:0]  occupancy,
  input logic        cfg_ready
);

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == 32'd0)
    else $error("result without hit carries a value");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) !cfg_ready |-> in_stall)
    else $error("requests open while configuration port is closed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind open_addressing_lru_cache_unit oalc_checker u_oalc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hit        (hit),
  .read_value (read_value),
  .occupancy  (occupancy),
  .cfg_ready  (cfg_ready)
);
